FILE: rtl/core/scaled_glyph_line_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the glyph line rasterizer
// Shorthand for clocked implication checks that are disabled during an active-low reset.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_LINE_RASTERIZER_ASSERT_SVH
`define SCALED_GLYPH_LINE_RASTERIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sglr_pkg.sv
// ----------------------------------------------------------------------------
// Glyph line rasterizer package
// Shared widths, types, the 5x7 font table and small lookup functions.
// ----------------------------------------------------------------------------
package sglr_pkg;

    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int ROM_ENTRIES = 42;
    localparam int GLYPH_IDX_W = 6;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int COORD_W     = 11;
    localparam int SCALE_W     = 3;
    localparam int PEN_X_W     = 13;
    localparam int PEN_Y_W     = 12;
    localparam int X_ACC_W     = 14;
    localparam int INK_W       = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [PEN_X_W-1:0] PEN_X_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 3'd2;
    localparam logic [COORD_W-1:0] FRAME_RESET = 11'd72;

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_NINE  = 7'h39;
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_Z     = 7'h5a;
    localparam logic [6:0] CHAR_QMARK = 7'h3f;
    localparam logic [6:0] CHAR_PLUS  = 7'h2b;
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_DOT   = 7'h2e;
    localparam logic [6:0] CHAR_SLASH = 7'h2f;

    localparam logic [GLYPH_IDX_W-1:0] GLYPH_SPACE  = 6'd0;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_QMARK  = 6'd1;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_PLUS   = 6'd2;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_MINUS  = 6'd3;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_DOT    = 6'd4;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_SLASH  = 6'd5;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_DIGIT0 = 6'd6;
    localparam logic [GLYPH_IDX_W-1:0] GLYPH_LETTERA = 6'd16;

    // Row 0 is element 0; bit 4 of a row is the leftmost column.
    typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] t_glyph;

    typedef struct packed {
        t_glyph             rows;
        logic [COL_W-1:0]   left;
        logic [COL_W-1:0]   right;
        logic [INK_W-1:0]   ink;
        logic               space;
        logic               inkless;
    } t_glyph_info;

    typedef struct packed {
        logic init;
        logic step_col;
        logic step_row;
    } t_cell_ctrl;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
    } t_rect;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // Maps an ASCII code to its font table entry; anything unknown becomes '?'.
    function automatic logic [GLYPH_IDX_W-1:0] f_code_index(input logic [6:0] code);
        logic [6:0] idx;
        idx = {1'b0, GLYPH_QMARK};
        if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
            idx = code - CHAR_ZERO + {1'b0, GLYPH_DIGIT0};
        end else if (code >= CHAR_A && code <= CHAR_Z) begin
            idx = code - CHAR_A + {1'b0, GLYPH_LETTERA};
        end else begin
            case (code)
                CHAR_SPACE: idx = {1'b0, GLYPH_SPACE};
                CHAR_PLUS:  idx = {1'b0, GLYPH_PLUS};
                CHAR_MINUS: idx = {1'b0, GLYPH_MINUS};
                CHAR_DOT:   idx = {1'b0, GLYPH_DOT};
                CHAR_SLASH: idx = {1'b0, GLYPH_SLASH};
                default:    idx = {1'b0, GLYPH_QMARK};
            endcase
        end
        return idx[GLYPH_IDX_W-1:0];
    endfunction

    function automatic t_glyph f_font(input logic [GLYPH_IDX_W-1:0] idx);
        t_glyph g;
        case (idx)
            6'd0:  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            6'd1:  g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
            6'd2:  g = {5'h00, 5'h04, 5'h04, 5'h1f, 5'h04, 5'h04, 5'h00};
            6'd3:  g = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            6'd4:  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
            6'd5:  g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00};
            6'd6:  g = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            6'd7:  g = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            6'd8:  g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            6'd9:  g = {5'h1e, 5'h01, 5'h01, 5'h0e, 5'h01, 5'h01, 5'h1e};
            6'd10: g = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            6'd11: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h1e};
            6'd12: g = {5'h0e, 5'h10, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            6'd13: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            6'd14: g = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            6'd15: g = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h01, 5'h0e};
            6'd16: g = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            6'd17: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            6'd18: g = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
            6'd19: g = {5'h1c, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1c};
            6'd20: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
            6'd21: g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
            6'd22: g = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0e};
            6'd23: g = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            6'd24: g = {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            6'd25: g = {5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0e};
            6'd26: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            6'd27: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
            6'd28: g = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            6'd29: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            6'd30: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            6'd31: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            6'd32: g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
            6'd33: g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            6'd34: g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            6'd35: g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            6'd36: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            6'd37: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
            6'd38: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
            6'd39: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
            6'd40: g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
            6'd41: g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
            default: g = '0;
        endcase
        return g;
    endfunction

    // Gap after a glyph: max(1, (scale + 1) / 3).
    function automatic logic [1:0] f_spacing(input logic [SCALE_W-1:0] scale);
        logic [1:0] sp;
        sp = (scale >= 3'd5) ? 2'd2 : 2'd1;
        return sp;
    endfunction

endpackage

FILE: rtl/core/sglr_glyph.sv
// ----------------------------------------------------------------------------
// Glyph lookup
// Finds the font entry of a character and its left and right ink columns.
// ----------------------------------------------------------------------------
module sglr_glyph #(
    parameter int GLYPH_COUNT = 42
) (
    input  logic [6:0]           i_code,
    output sglr_pkg::t_glyph_info o_info
);
    import sglr_pkg::*;

    localparam int GlyphLimit = (GLYPH_COUNT < ROM_ENTRIES) ? GLYPH_COUNT : ROM_ENTRIES;
    localparam logic [GLYPH_IDX_W:0] LimitW = (GLYPH_IDX_W+1)'(GlyphLimit);

    logic [GLYPH_IDX_W-1:0] w_raw_idx;
    logic [GLYPH_IDX_W-1:0] w_idx;
    t_glyph                 w_rows;
    logic [GLYPH_COLS-1:0]  w_mask;
    logic [COL_W-1:0]       w_left;
    logic [COL_W-1:0]       w_right;

    assign w_raw_idx = f_code_index(i_code);
    assign w_idx     = ({1'b0, w_raw_idx} < LimitW) ? w_raw_idx : GLYPH_QMARK;
    assign w_rows    = f_font(w_idx);

    always_comb begin
        w_mask = '0;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            w_mask = w_mask | w_rows[r];
        end
        // Scan from the right so the leftmost lit column wins.
        w_left = '0;
        for (int c = GLYPH_COLS - 1; c >= 0; c--) begin
            if (w_mask[GLYPH_COLS-1-c]) begin
                w_left = COL_W'(c);
            end
        end
        w_right = '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
            if (w_mask[GLYPH_COLS-1-c]) begin
                w_right = COL_W'(c);
            end
        end
    end

    always_comb begin
        o_info.rows    = w_rows;
        o_info.left    = w_left;
        o_info.right   = w_right;
        o_info.space   = (i_code == CHAR_SPACE);
        o_info.inkless = (w_mask == '0);
        if (o_info.space) begin
            o_info.ink = INK_W'(2);
        end else if (o_info.inkless) begin
            o_info.ink = INK_W'(3);
        end else begin
            o_info.ink = w_right - w_left + INK_W'(1);
        end
    end

endmodule

FILE: rtl/core/sglr_cell_unit.sv
// ----------------------------------------------------------------------------
// Cell rectangle unit
// Steps the cell edges by the scale and clips the current cell to the frame.
// ----------------------------------------------------------------------------
module sglr_cell_unit (
    input  logic                                i_clk,
    input  sglr_pkg::t_cell_ctrl                i_ctrl,
    input  logic [sglr_pkg::PEN_X_W-1:0]        i_pen_x,
    input  logic signed [sglr_pkg::PEN_Y_W-1:0] i_pen_y,
    input  logic [sglr_pkg::SCALE_W-1:0]        i_scale,
    input  logic [sglr_pkg::COORD_W-1:0]        i_frame_w,
    input  logic [sglr_pkg::COORD_W-1:0]        i_frame_h,
    output sglr_pkg::t_rect                     o_rect,
    output logic                                o_nonempty
);
    import sglr_pkg::*;

    logic [X_ACC_W-1:0]        r_x_lo, r_x_hi;
    logic signed [PEN_Y_W-1:0] r_y_lo, r_y_hi;
    logic [X_ACC_W-1:0]        w_x_base, w_x_next;
    logic signed [PEN_Y_W-1:0] w_y_base, w_y_next;

    // One adder per axis: the next edge is always the base plus the scale.
    assign w_x_base = (i_ctrl.init || i_ctrl.step_row) ? {1'b0, i_pen_x} : r_x_hi;
    assign w_x_next = w_x_base + X_ACC_W'(i_scale);
    assign w_y_base = i_ctrl.init ? i_pen_y : r_y_hi;
    assign w_y_next = w_y_base + $signed({{(PEN_Y_W-SCALE_W){1'b0}}, i_scale});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.init || i_ctrl.step_col || i_ctrl.step_row) begin
            r_x_lo <= w_x_base;
            r_x_hi <= w_x_next;
        end
        if (i_ctrl.init || i_ctrl.step_row) begin
            r_y_lo <= w_y_base;
            r_y_hi <= w_y_next;
        end
    end

    function automatic logic [COORD_W-1:0] f_clip_x(input logic [X_ACC_W-1:0] v,
                                                    input logic [COORD_W-1:0] hi);
        logic [COORD_W-1:0] res;
        res = (v > X_ACC_W'(hi)) ? hi : v[COORD_W-1:0];
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] f_clip_y(input logic signed [PEN_Y_W-1:0] v,
                                                    input logic [COORD_W-1:0] hi);
        logic [COORD_W-1:0] res;
        if (v[PEN_Y_W-1]) begin
            res = '0;
        end else begin
            res = (v[COORD_W-1:0] > hi) ? hi : v[COORD_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        o_rect.x0  = f_clip_x(r_x_lo, i_frame_w);
        o_rect.x1  = f_clip_x(r_x_hi, i_frame_w);
        o_rect.y0  = f_clip_y(r_y_lo, i_frame_h);
        o_rect.y1  = f_clip_y(r_y_hi, i_frame_h);
        o_nonempty = (o_rect.x0 < o_rect.x1) && (o_rect.y0 < o_rect.y1);
    end

endmodule

FILE: rtl/core/scaled_glyph_line_rasterizer.sv
// ----------------------------------------------------------------------------
// Scaled glyph line rasterizer
// Draws a line of 5x7 font characters as a stream of clipped pixel rectangles.
// ----------------------------------------------------------------------------
// One character arrives per slave beat. tuser set loads the pen from line_x and
// line_y before drawing. Each lit font cell becomes one scale-by-scale
// rectangle clipped to the frame; empty rectangles are dropped, and tlast marks
// the final rectangle of a character. A character with nothing visible gives no
// beat at all. The pen then moves right by the ink width times the scale plus
// the character gap.
// Sequence: the character is accepted, its font entry is looked up, the cells
// of its ink columns are scanned in row-major order through the cell unit,
// and a closing step ends the character. Spaces and inkless glyphs skip the
// scan. A rectangle is held until the next drawn cell or the closing step so
// the last one can be flagged, and shows on the master side in the cycle after
// that, so it leaves through the hold register and then the output register.
// A stalled master side halts the scan at the next drawn cell while a
// rectangle is held and the output register is full, and holds the closing
// step the same way. Reset returns the pen to the origin, the scale to 2 and
// the frame to 72 by 72, and empties the output.
// Configuration writes are always taken and belong between characters.
// ----------------------------------------------------------------------------
`include "scaled_glyph_line_rasterizer_assert.svh"

module scaled_glyph_line_rasterizer #(
    parameter int GLYPH_COUNT = 42
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Character channel.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [31:0]                        i_s_tdata,  // char_code, line_x, line_y, pad
    input  logic                               i_s_tuser,  // line_start
    // Rectangle channel.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [47:0]                        o_m_tdata,  // rect_x0, rect_y0, rect_x1, rect_y1, pad
    output logic                               o_m_tlast,  // last_rect
    // Configuration writes.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sglr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sglr_pkg::COORD_W-1:0]       i_cfg_data
);
    import sglr_pkg::*;

    localparam logic [ROW_W-1:0] RowLast = ROW_W'(GLYPH_ROWS - 1);

    // Configuration registers.
    logic [SCALE_W-1:0]        r_scale;
    logic [COORD_W-1:0]        r_frame_w, r_frame_h;

    // Sequencer state and pen.
    t_state                    r_state, n_state;
    logic [PEN_X_W-1:0]        r_pen_x;
    logic signed [PEN_Y_W-1:0] r_pen_y;
    logic [6:0]                r_char;
    t_glyph_info               r_info;
    logic [ROW_W-1:0]          r_row;
    logic [COL_W-1:0]          r_col;

    // One-deep hold for the latest rectangle, then the output register.
    t_rect                     r_pend;
    logic                      r_pend_valid;
    t_rect                     r_out;
    logic                      r_out_last;
    logic                      r_out_valid;

    t_glyph_info               w_info;
    t_cell_ctrl                w_ctrl;
    t_rect                     w_rect;
    logic                      w_nonempty;
    logic                      w_in_accept;
    logic                      w_out_free;
    logic                      w_lit;
    logic                      w_hit;
    logic                      w_last_cell;
    logic                      w_step;
    logic                      w_push;
    logic                      w_push_last;
    logic                      w_load_pend;
    logic                      w_clear_pend;
    logic                      w_advance;
    logic [6:0]                w_adv;
    logic [X_ACC_W-1:0]        w_pen_sum;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_in_accept = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {4'b0, r_out.y1, r_out.x1, r_out.y0, r_out.x0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= SCALE_RESET;
            r_frame_w <= FRAME_RESET;
            r_frame_h <= FRAME_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCALE:   r_scale   <= i_cfg_data[SCALE_W-1:0];
                CFG_FRAME_W: r_frame_w <= i_cfg_data;
                CFG_FRAME_H: r_frame_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sglr_glyph #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_glyph (
        .i_code (r_char),
        .o_info (w_info)
    );

    sglr_cell_unit u_cell (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_pen_x    (r_pen_x),
        .i_pen_y    (r_pen_y),
        .i_scale    (r_scale),
        .i_frame_w  (r_frame_w),
        .i_frame_h  (r_frame_h),
        .o_rect     (w_rect),
        .o_nonempty (w_nonempty)
    );

    // Current font cell, in row-major order across the ink columns only.
    assign w_lit       = r_info.rows[r_row][COL_W'(GLYPH_COLS - 1) - r_col];
    assign w_hit       = w_lit && w_nonempty;
    assign w_last_cell = (r_row == RowLast) && (r_col == r_info.right);

    // Pen advance: ink width times scale plus the gap, saturating.
    assign w_adv     = 7'(r_info.ink) * 7'(r_scale) + 7'(f_spacing(r_scale));
    assign w_pen_sum = {1'b0, r_pen_x} + X_ACC_W'(w_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_ctrl       = '0;
        w_step       = 1'b0;
        w_push       = 1'b0;
        w_push_last  = 1'b0;
        w_load_pend  = 1'b0;
        w_clear_pend = 1'b0;
        w_advance    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                w_ctrl.init = 1'b1;
                if (w_info.space || w_info.inkless) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // A new hit must first move the held rectangle out.
                if (!(w_hit && r_pend_valid && !w_out_free)) begin
                    w_step = 1'b1;
                    if (w_hit) begin
                        w_load_pend = 1'b1;
                        w_push      = r_pend_valid;
                    end
                    if (w_last_cell) begin
                        n_state = ST_FLUSH;
                    end else if (r_col == r_info.right) begin
                        w_ctrl.step_row = 1'b1;
                    end else begin
                        w_ctrl.step_col = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    w_advance = 1'b1;
                    n_state   = ST_IDLE;
                end else if (w_out_free) begin
                    w_push       = 1'b1;
                    w_push_last  = 1'b1;
                    w_clear_pend = 1'b1;
                    w_advance    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Pen and valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_accept && i_s_tuser) begin
                r_pen_x <= {3'b0, i_s_tdata[16:7]};
                r_pen_y <= {i_s_tdata[27], i_s_tdata[27:17]};
            end else if (w_advance) begin
                r_pen_x <= (w_pen_sum > X_ACC_W'(PEN_X_MAX)) ? PEN_X_MAX
                                                              : w_pen_sum[PEN_X_W-1:0];
            end
            if (w_load_pend) begin
                r_pend_valid <= 1'b1;
            end else if (w_clear_pend) begin
                r_pend_valid <= 1'b0;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_char <= i_s_tdata[6:0];
        end
        if (r_state == ST_LOOKUP) begin
            r_info <= w_info;
            r_row  <= '0;
            r_col  <= w_info.left;
        end else if (w_step) begin
            if (r_col == r_info.right) begin
                r_col <= r_info.left;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
        if (w_load_pend) begin
            r_pend <= w_rect;
        end
        if (w_push) begin
            r_out      <= r_pend;
            r_out_last <= w_push_last;
        end
    end

    `SGLR_ASSERT_SAME(a_ready_no_hold, i_clk, i_rst_n, o_s_tready, !r_pend_valid, "held rectangle left behind while taking a character")
    `SGLR_ASSERT_SAME(a_hold_in_scan, i_clk, i_rst_n, r_pend_valid, (r_state == ST_SCAN) || (r_state == ST_FLUSH), "rectangle held outside the scan")
    `SGLR_ASSERT_SAME(a_cell_in_ink, i_clk, i_rst_n, r_state == ST_SCAN, (r_row <= RowLast) && (r_col >= r_info.left) && (r_col <= r_info.right), "scan cell outside the ink columns")
    `SGLR_ASSERT_NEXT(a_accept_lookup, i_clk, i_rst_n, w_in_accept, r_state == ST_LOOKUP, "accepted character not looked up")

endmodule
